[hw/rtl/tphc_pkg.sv]
// ----------------------------------------------------------------------------
// tphc_pkg: shared types and constants of the TCP pseudo-header checksum
// Field offsets of the IPv4 header, queue sizing and the per-byte entry
// passed from the byte parser to the checksum accumulator.
// ----------------------------------------------------------------------------
package tphc_pkg;

  // IPv4 header layout (byte offsets)
  localparam logic [15:0] ADDR_FIRST      = 16'd12;
  localparam logic [15:0] ADDR_END        = 16'd20;
  localparam logic [5:0]  FIXED_HDR_BYTES = 6'd20;
  localparam logic [3:0]  MIN_IHL         = 4'd5;
  localparam logic [15:0] POS_MAX         = 16'hffff;

  // protocol number for TCP, reset value of the pseudo-header protocol
  localparam logic [7:0]  TCP_PROTO_NUM   = 8'd6;

  // parser-to-accumulator queue
  localparam int unsigned FIFO_AW    = 2;
  localparam int unsigned FIFO_DEPTH = 1 << FIFO_AW;

  // one accepted byte, reduced to what the accumulator needs
  typedef struct packed {
    logic [15:0] word;     // 16-bit word to add, zero if none
    logic [15:0] seglen;   // segment length, meaningful with last
    logic        bad;      // malformed flag, meaningful with last
    logic        last;     // final byte of the datagram
  } tphc_entry_t;

endpackage

[hw/rtl/tphc_front.sv]
// ----------------------------------------------------------------------------
// tphc_front: IPv4 byte parser
// Tracks the byte position, header length and total length, pairs segment
// bytes into words and emits one queue entry for every accepted byte.
// ----------------------------------------------------------------------------
module tphc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  output logic                 q_valid,
  input  logic                 q_ready,
  output tphc_pkg::tphc_entry_t q_entry
);

  logic [15:0] byte_position;
  logic [3:0]  header_words;
  logic [15:0] total_length;
  logic [7:0]  held_high_byte;
  logic        odd_byte_pending;

  logic        accept;
  logic [3:0]  hw_cur;
  logic [15:0] tl_cur;
  logic [5:0]  seg_start;
  logic [15:0] start_ext;
  logic        is_addr;
  logic        is_seg;
  logic        pending_next;
  logic [7:0]  held_next;
  logic [15:0] word;
  logic [16:0] count;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign accept   = in_valid && q_ready;

  // Decode header fields as updated by this byte
  always_comb begin
    hw_cur = (byte_position == 16'd0) ? data_byte[3:0] : header_words;
    case (byte_position)
      16'd0:   tl_cur = 16'd0;
      16'd2:   tl_cur = {data_byte, total_length[7:0]};
      16'd3:   tl_cur = {total_length[15:8], data_byte};
      default: tl_cur = total_length;
    endcase
    seg_start = (hw_cur < tphc_pkg::MIN_IHL) ? tphc_pkg::FIXED_HDR_BYTES : {hw_cur, 2'b00};
    start_ext = {10'd0, seg_start};
    is_addr   = (byte_position >= tphc_pkg::ADDR_FIRST) && (byte_position < tphc_pkg::ADDR_END);
    is_seg    = !is_addr && (byte_position >= start_ext) && (byte_position < tl_cur);
    count     = {1'b0, byte_position} + 17'd1;
  end

  // Classify the byte: address half-word, segment pair, or nothing
  always_comb begin
    pending_next = odd_byte_pending;
    held_next    = held_high_byte;
    word         = 16'd0;
    if (is_addr) begin
      word = byte_position[0] ? {8'd0, data_byte} : {data_byte, 8'd0};
    end else if (is_seg) begin
      if (odd_byte_pending) begin
        word         = {held_high_byte, data_byte};
        pending_next = 1'b0;
      end else begin
        held_next    = data_byte;
        pending_next = 1'b1;
      end
    end
    // pad a lone final segment byte with zero
    if (last_byte && pending_next) begin
      word = {held_next, 8'd0};
    end
  end

  // Build the queue entry
  always_comb begin
    q_entry.word   = word;
    q_entry.last   = last_byte;
    q_entry.seglen = (tl_cur >= start_ext) ? (tl_cur - start_ext) : 16'd0;
    q_entry.bad    = (hw_cur < tphc_pkg::MIN_IHL) || (tl_cur < start_ext) ||
                     (count < {1'b0, tl_cur});
  end

  // Advance parser state, clear after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= 16'd0;
      header_words     <= 4'd0;
      total_length     <= 16'd0;
      held_high_byte   <= 8'd0;
      odd_byte_pending <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        byte_position    <= 16'd0;
        header_words     <= 4'd0;
        total_length     <= 16'd0;
        held_high_byte   <= 8'd0;
        odd_byte_pending <= 1'b0;
      end else begin
        if (byte_position != tphc_pkg::POS_MAX) begin
          byte_position <= byte_position + 16'd1;
        end
        header_words     <= hw_cur;
        total_length     <= tl_cur;
        held_high_byte   <= held_next;
        odd_byte_pending <= pending_next;
      end
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && last_byte |=> byte_position == 16'd0 && !odd_byte_pending)
    else $error("parser state not cleared after final byte");

  a_pending_in_segment: assert property (@(posedge clk) disable iff (rst)
    odd_byte_pending |-> byte_position > tphc_pkg::ADDR_END)
    else $error("held byte pending before the segment region");
`endif

endmodule

[hw/rtl/tphc_fifo.sv]
// ----------------------------------------------------------------------------
// tphc_fifo: entry queue between parser and accumulator
// Small register-based FIFO so that each side can stall on its own.
// ----------------------------------------------------------------------------
module tphc_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_valid,
  output logic                  wr_ready,
  input  tphc_pkg::tphc_entry_t wr_entry,
  output logic                  rd_valid,
  input  logic                  rd_ready,
  output tphc_pkg::tphc_entry_t rd_entry
);

  tphc_pkg::tphc_entry_t        mem [tphc_pkg::FIFO_DEPTH];
  logic [tphc_pkg::FIFO_AW-1:0] wr_ptr;
  logic [tphc_pkg::FIFO_AW-1:0] rd_ptr;
  logic [tphc_pkg::FIFO_AW:0]   count;
  logic                         push;
  logic                         pop;

  assign wr_ready = (count != (tphc_pkg::FIFO_AW + 1)'(tphc_pkg::FIFO_DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_entry = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (tphc_pkg::FIFO_AW + 1)'(tphc_pkg::FIFO_DEPTH))
    else $error("queue occupancy out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    wr_ptr - rd_ptr == count[tphc_pkg::FIFO_AW-1:0])
    else $error("queue pointers disagree with occupancy");
`endif

endmodule

[hw/rtl/tphc_back.sv]
// ----------------------------------------------------------------------------
// tphc_back: ones' complement accumulator and result register
// Adds each queued word with end-around carry; on the final byte adds the
// protocol and segment length, folds, complements and holds the result.
// ----------------------------------------------------------------------------
module tphc_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            pseudo_protocol,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  tphc_pkg::tphc_entry_t q_entry,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           checksum,
  output logic [15:0]           segment_length,
  output logic                  malformed
);

  logic [15:0] running_sum;
  logic        pop;
  logic [17:0] part_sum;
  logic [16:0] part_fold;
  logic [15:0] sum_next;
  logic [17:0] fin_sum;
  logic [16:0] fin_fold1;
  logic [16:0] fin_fold2;

  // Only a final entry needs room in the result register
  assign q_ready = !q_entry.last || !out_valid || out_ready;
  assign pop     = q_valid && q_ready;

  // Ones' complement sums
  always_comb begin
    part_sum  = {2'd0, running_sum} + {2'd0, q_entry.word};
    part_fold = {1'b0, part_sum[15:0]} + {15'd0, part_sum[17:16]};
    sum_next  = part_fold[15:0] + {15'd0, part_fold[16]};

    fin_sum   = {2'd0, running_sum} + {2'd0, q_entry.word} +
                {10'd0, pseudo_protocol} + {2'd0, q_entry.seglen};
    fin_fold1 = {1'b0, fin_sum[15:0]} + {15'd0, fin_sum[17:16]};
    fin_fold2 = {1'b0, fin_fold1[15:0]} + {16'd0, fin_fold1[16]};
  end

  // Accumulate, restart after each datagram
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= 16'd0;
    end else if (pop) begin
      running_sum <= q_entry.last ? 16'd0 : sum_next;
    end
  end

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && q_entry.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_entry.last) begin
      checksum       <= ~fin_fold2[15:0];
      segment_length <= q_entry.seglen;
      malformed      <= q_entry.bad;
    end
  end

`ifndef ASSERT_OFF
  a_result_after_last: assert property (@(posedge clk) disable iff (rst)
    pop && q_entry.last |=> out_valid && running_sum == 16'd0)
    else $error("final entry did not produce a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && q_valid && q_entry.last |-> !pop)
    else $error("pending result overwritten");
`endif

endmodule

[hw/rtl/tcp_pseudo_header_checksum.sv]
// ----------------------------------------------------------------------------
// tcp_pseudo_header_checksum: TCP checksum over an IPv4 datagram
// Sums the pseudo-header and the segment of a byte-streamed IPv4 datagram
// and returns the complemented ones' complement checksum per datagram.
//
//   channel  direction  signals                  contents
//   s_*      in         tvalid tready tdata tlast one datagram byte, tlast on final
//   m_*      out        tvalid tready tdata tuser one result per datagram
//   cfg_*    in         valid ready data          pseudo-header protocol number
//
// One byte is accepted every clock while the queue has room; the parser classifies
// it in the same cycle into a four-entry queue and the accumulator retires one
// entry per clock unless a final entry waits for the result register. With the
// queue empty, the final entry passes the queue register and then sets m_tvalid;
// the result waits in an output register while next-datagram bytes keep flowing.
// Reset (rst, synchronous) clears all state and sets the protocol to 6.
// Stalls on the result side back up through the queue to s_tready.
// ----------------------------------------------------------------------------
module tcp_pseudo_header_checksum (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data_byte
  input  logic        s_tlast,    // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [15:0] checksum, [31:16] segment_length
  output logic        m_tuser,    // malformed
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // pseudo_protocol
);

  logic [7:0]            pseudo_protocol;
  logic                  fq_valid;
  logic                  fq_ready;
  tphc_pkg::tphc_entry_t fq_entry;
  logic                  qb_valid;
  logic                  qb_ready;
  tphc_pkg::tphc_entry_t qb_entry;
  logic [15:0]           checksum;
  logic [15:0]           segment_length;

  // Protocol register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pseudo_protocol <= tphc_pkg::TCP_PROTO_NUM;
    end else if (cfg_valid) begin
      pseudo_protocol <= cfg_data;
    end
  end

  tphc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_entry   (fq_entry)
  );

  tphc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_entry (fq_entry),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_entry (qb_entry)
  );

  tphc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .pseudo_protocol (pseudo_protocol),
    .q_valid         (qb_valid),
    .q_ready         (qb_ready),
    .q_entry         (qb_entry),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .checksum        (checksum),
    .segment_length  (segment_length),
    .malformed       (m_tuser)
  );

  // Pack the result
  assign m_tdata = {segment_length, checksum};

endmodule

[verif/tphc_sum_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tphc_sum_checker: result predictor and scoreboard for the TCP checksum block
// Watches the byte, result and protocol channels. Each accepted byte advances
// a private copy of the datagram state; a byte carrying tlast queues the
// expected checksum, segment length and malformed flag, which are compared
// field by field with each accepted result in order.
// ----------------------------------------------------------------------------
module tphc_sum_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data_byte
  input  logic        s_tlast,    // last_byte
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,    // [15:0] checksum, [31:16] segment_length
  input  logic        m_tuser,    // malformed
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,   // pseudo_protocol
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [15:0] csum;
    logic [15:0] seg_len;
    logic        bad;
  } dgram_result_t;

  dgram_result_t expected_sums[$];
  dgram_result_t want;

  // predicted block state
  logic [7:0]  proto;
  logic [15:0] pos;
  logic [3:0]  ihl;
  logic [15:0] tot_len;
  logic [15:0] sum;
  logic [7:0]  high_byte;
  logic        odd;

  // end-around-carry add, result stays within 16 bits
  function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] w);
    logic [16:0] s;
    s = {1'b0, acc} + {1'b0, w};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  function automatic void clear_datagram();
    pos       = '0;
    ihl       = '0;
    tot_len   = '0;
    sum       = '0;
    high_byte = '0;
    odd       = 1'b0;
  endfunction

  // advance the datagram state by one byte; queue a result on the final byte
  function automatic void take_byte(input logic [7:0] b, input logic last);
    logic [15:0] p;
    logic [15:0] seg_start;
    logic [15:0] seg_len;
    logic [16:0] seen;
    logic        bad;
    p = pos;
    if (p == 16'd0) begin
      ihl     = b[3:0];
      tot_len = '0;
    end else if (p == 16'd2) begin
      tot_len[15:8] = b;
    end else if (p == 16'd3) begin
      tot_len[7:0] = b;
    end
    // a short IHL still leaves the fixed 20-byte header in front
    seg_start = (ihl < tphc_pkg::MIN_IHL) ? {10'd0, tphc_pkg::FIXED_HDR_BYTES}
                                          : {10'd0, ihl, 2'b00};
    if (p >= tphc_pkg::ADDR_FIRST && p < tphc_pkg::ADDR_END) begin
      sum = ones_add(sum, p[0] ? {8'd0, b} : {b, 8'd0});
    end else if (p >= seg_start && p < tot_len) begin
      if (!odd) begin
        high_byte = b;
        odd       = 1'b1;
      end else begin
        sum = ones_add(sum, {high_byte, b});
        odd = 1'b0;
      end
    end
    if (pos != tphc_pkg::POS_MAX) pos = pos + 16'd1;
    if (last) begin
      seg_len = (tot_len >= seg_start) ? tot_len - seg_start : 16'd0;
      if (odd) sum = ones_add(sum, {high_byte, 8'd0});
      sum  = ones_add(sum, {8'd0, proto});
      sum  = ones_add(sum, seg_len);
      seen = {1'b0, p} + 17'd1;
      bad  = (ihl < tphc_pkg::MIN_IHL) || (tot_len < seg_start) ||
             (seen < {1'b0, tot_len});
      expected_sums.push_back({~sum, seg_len, bad});
      clear_datagram();
    end
  endfunction

  // track protocol writes, check results, then predict from accepted bytes
  always @(posedge clk) begin
    if (rst) begin
      expected_sums.delete();
      proto  = tphc_pkg::TCP_PROTO_NUM;
      errors = 0;
      clear_datagram();
    end else begin
      if (cfg_valid && cfg_ready) proto = cfg_data;
      if (m_tvalid && m_tready) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: unexpected result: checksum %h, segment_length %h, malformed %b",
                   $time, m_tdata[15:0], m_tdata[31:16], m_tuser);
          errors++;
        end else begin
          want = expected_sums.pop_front();
          if (m_tdata[15:0] !== want.csum) begin
            $display("%0t: checksum mismatch: expected %h, got %h",
                     $time, want.csum, m_tdata[15:0]);
            errors++;
          end
          if (m_tdata[31:16] !== want.seg_len) begin
            $display("%0t: segment_length mismatch: expected %h, got %h",
                     $time, want.seg_len, m_tdata[31:16]);
            errors++;
          end
          if (m_tuser !== want.bad) begin
            $display("%0t: malformed mismatch: expected %b, got %b",
                     $time, want.bad, m_tuser);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) take_byte(s_tdata, s_tlast);
    end
    pending = expected_sums.size();
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top of the TCP pseudo-header checksum block
// Streams directed and random IPv4 datagrams byte by byte through the block
// under three idling mixes, rewrites the protocol number between phases and
// stalls the result side to back the block up. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_CYCLES  = 100;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] data_byte
  logic        s_tlast;    // last_byte
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;    // [15:0] checksum, [31:16] segment_length
  logic        m_tuser;    // malformed
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;   // pseudo_protocol

  int          errors;
  int          pending;
  int          cycles = 0;
  int          snd_idle_pct;
  int          rcv_idle_pct;
  int unsigned bytes_sent = 0;
  int unsigned grams_sent = 0;
  logic        hold_req;
  logic        hold_ack = 1'b0;
  int          hold_left = 0;

  tcp_pseudo_header_checksum dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  tphc_sum_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always #2 clk = ~clk;

  // abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** tcp_pseudo_header_checksum: FAILED **");
      $finish;
    end
  end

  // result side: random backpressure, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // offer one byte, with random gaps ahead of it, and wait for its transaction
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
  endtask

  // one datagram: IHL in byte 0, total length in bytes 2..3, rest per fill
  task automatic send_datagram(input logic [3:0] ihl, input logic [15:0] total,
                               input int unsigned count, input fill_t fill);
    logic [7:0] b;
    for (int unsigned i = 0; i < count; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hff;
        default:   b = 8'($urandom_range(255));
      endcase
      if (i == 0) begin
        b = {4'($urandom_range(15)), ihl};
      end else if (i == 2) begin
        b = total[15:8];
      end else if (i == 3) begin
        b = total[7:0];
      end
      send_byte(b, i == count - 1);
    end
    bytes_sent += count;
    grams_sent++;
  endtask

  // mostly well-formed datagrams with small segments, the rest broken
  task automatic send_random_datagram();
    logic [3:0]  ihl;
    int unsigned hdr;
    int unsigned total;
    int unsigned count;
    int unsigned pick;
    pick  = $urandom_range(99);
    ihl   = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 5)) : tphc_pkg::MIN_IHL;
    hdr   = ihl * 4;
    total = hdr + $urandom_range(14);
    count = total;
    if (pick < 70) begin
      count = total;
    end else if (pick < 80) begin
      count = total + $urandom_range(6, 1);
    end else if (pick < 87) begin
      count = $urandom_range(total - 1, 1);
    end else if (pick < 93) begin
      ihl   = 4'($urandom_range(4));
      total = 20 + $urandom_range(12);
      count = total;
    end else if (pick < 97) begin
      total = $urandom_range(hdr - 1);
      count = $urandom_range(hdr + 4, 4);
    end else begin
      total = $urandom_range(65535);
      count = $urandom_range(40, 1);
    end
    send_datagram(ihl, total[15:0], count, FILL_RANDOM);
  endtask

  task automatic run_random(input int unsigned min_bytes, input int unsigned min_grams);
    int unsigned b0;
    int unsigned g0;
    b0 = bytes_sent;
    g0 = grams_sent;
    while (bytes_sent - b0 < min_bytes || grams_sent - g0 < min_grams) begin
      send_random_datagram();
    end
  endtask

  // drop valid, wait for every result, then let the pipeline settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_protocol(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst          <= 1'b1;
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    s_tlast      <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_data     <= '0;
    hold_req     <= 1'b0;
    rcv_idle_pct <= 75;
    snd_idle_pct = 27;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed datagrams under the reset protocol number
    send_datagram(tphc_pkg::MIN_IHL, 16'd20, 1, FILL_RANDOM);   // ends before total length
    send_datagram(tphc_pkg::MIN_IHL, 16'd40, 3, FILL_RANDOM);   // ends with half a total
    send_datagram(tphc_pkg::MIN_IHL, 16'd21, 21, FILL_ONES);    // lone odd segment byte
    send_datagram(tphc_pkg::MIN_IHL, 16'd22, 22, FILL_ZERO);
    send_datagram(4'd0, 16'd22, 22, FILL_RANDOM);               // header length too short
    send_datagram(4'd15, 16'd30, 34, FILL_RANDOM);              // total shorter than header
    send_datagram(tphc_pkg::MIN_IHL, 16'd23, 27, FILL_RANDOM);  // bytes past total length
    send_datagram(tphc_pkg::MIN_IHL, 16'hffff, 24, FILL_RANDOM);
    wait_drained();
    write_protocol(8'hff);

    // sender idles lightly, receiver heavily
    run_random(45, 2);
    wait_drained();
    write_protocol(8'h00);

    // and the other way round
    snd_idle_pct = 75;
    rcv_idle_pct <= 27;
    run_random(45, 2);
    wait_drained();
    write_protocol(8'($urandom_range(255)));

    // no idling; hold the result side while tiny datagrams pile up
    snd_idle_pct = 0;
    rcv_idle_pct <= 0;
    hold_req <= ~hold_req;
    repeat (30) begin
      send_datagram(tphc_pkg::MIN_IHL, 16'($urandom_range(65535)), $urandom_range(3, 1),
                    FILL_RANDOM);
    end
    wait_drained();
    run_random(45, 2);
    wait_drained();
    write_protocol(8'd17);

    // unhindered traffic under a fresh protocol number
    run_random(45, 2);
    wait_drained();

    if (errors == 0 && pending == 0) begin
      $display("** tcp_pseudo_header_checksum: PASSED **");
    end else begin
      $display("** tcp_pseudo_header_checksum: FAILED **");
    end
    $finish;
  end

endmodule
